FILE: hw/rtl/ustar_pkg.sv
// ----------------------------------------------------------------------------
// USTAR walker package
// Types, header field offsets and record codes shared by the walker modules.
// ----------------------------------------------------------------------------
package ustar_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;

    localparam int HDR_IDX_W = 9;
    localparam int SIZE_W    = 32;
    localparam int COUNT_W   = 23;
    localparam int STATUS_W  = 2;

    localparam logic [HDR_IDX_W-1:0] NAME_POS    = 9'd0;
    localparam logic [HDR_IDX_W-1:0] SIZE_FIRST  = 9'd124;
    localparam logic [HDR_IDX_W-1:0] SIZE_END    = 9'd136;
    localparam logic [HDR_IDX_W-1:0] TYPE_POS    = 9'd156;
    localparam logic [HDR_IDX_W-1:0] MAGIC_FIRST = 9'd257;
    localparam logic [HDR_IDX_W-1:0] MAGIC_END   = 9'd262;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST    = 9'd511;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;

    localparam logic [SIZE_W-1:0] BLOCK_ROUND = 32'd511;
    localparam logic [SIZE_W-1:0] BLOCK_MASK  = ~32'd511;

    localparam logic REC_FILE = 1'b0;
    localparam logic REC_END  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       is_final;
    } ustar_in_t;

    typedef struct packed {
        logic                record_kind;
        logic [COUNT_W-1:0]  entry_index;
        logic [31:0]         data_offset;
        logic [SIZE_W-1:0]   file_size;
        logic [STATUS_W-1:0] end_status;
        logic [COUNT_W-1:0]  files_seen;
        logic                last_of_run;
    } ustar_result_t;

    typedef struct packed {
        logic [1:0]    count;
        ustar_result_t first;
        ustar_result_t second;
    } ustar_push_t;

    function automatic logic [7:0] magic_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/ustar_if.sv
// ----------------------------------------------------------------------------
// USTAR walker channels
// Valid/ready channels for archive bytes and for walker records.
// ----------------------------------------------------------------------------
interface ustar_in_if import ustar_pkg::*; ();
    logic      valid;
    logic      ready;
    ustar_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ustar_out_if import ustar_pkg::*; ();
    logic          valid;
    logic          ready;
    ustar_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ustar_hdr_parser.sv
// ----------------------------------------------------------------------------
// USTAR header parser
// Registers each archive byte, updates the walk state and forms up to two
// records per item for the result queue.
// ----------------------------------------------------------------------------
module ustar_hdr_parser import ustar_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ustar_in_if.sink     byte_in,
    input  logic         room,
    output ustar_push_t  push
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_final_reg;
    logic                   fire;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic                   in_header_reg, in_header_next;
    logic [SIZE_W-1:0]      skip_reg, skip_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic                   size_ended_reg, size_ended_next;
    logic [7:0]             type_reg, type_next;
    logic                   name_empty_reg, name_empty_next;
    logic                   magic_ok_reg, magic_ok_next;
    logic                   first_pending_reg, first_pending_next;
    logic                   stopped_reg, stopped_next;
    logic [COUNT_W-1:0]     regular_count_reg, regular_count_next;

    logic [1:0]             n;
    ustar_result_t          rec0, rec1, end_rec;
    logic [STATUS_W-1:0]    status;
    logic [SIZE_W-1:0]      rounded;

    assign fire          = in_valid_reg && room;
    assign byte_in.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            in_byte_reg  <= byte_in.data.archive_byte;
            in_final_reg <= byte_in.data.is_final;
        end
    end

    always_comb
    begin
        pos_next           = pos_reg;
        hdr_idx_next       = hdr_idx_reg;
        in_header_next     = in_header_reg;
        skip_next          = skip_reg;
        size_next          = size_reg;
        size_ended_next    = size_ended_reg;
        type_next          = type_reg;
        name_empty_next    = name_empty_reg;
        magic_ok_next      = magic_ok_reg;
        first_pending_next = first_pending_reg;
        stopped_next       = stopped_reg;
        regular_count_next = regular_count_reg;
        n                  = 2'd0;
        rec0               = '0;
        rec1               = '0;
        end_rec            = '0;
        status             = STATUS_OK;
        rounded            = (size_reg + BLOCK_ROUND) & BLOCK_MASK;

        if (!stopped_reg)
        begin
            if (in_header_reg)
            begin
                if (hdr_idx_reg == NAME_POS)
                begin
                    name_empty_next = (in_byte_reg == CHAR_NUL);
                end
                if (hdr_idx_reg >= SIZE_FIRST && hdr_idx_reg < SIZE_END && !size_ended_reg)
                begin
                    if (in_byte_reg == CHAR_NUL)
                    begin
                        size_ended_next = 1'b1;
                    end
                    else if (in_byte_reg >= CHAR_ZERO && in_byte_reg <= CHAR_SEVEN)
                    begin
                        size_next = {size_reg[SIZE_W-4:0], in_byte_reg[2:0]};
                    end
                end
                if (hdr_idx_reg == TYPE_POS)
                begin
                    type_next = in_byte_reg;
                end
                if (hdr_idx_reg >= MAGIC_FIRST && hdr_idx_reg < MAGIC_END && first_pending_reg
                    && in_byte_reg != magic_char(3'(hdr_idx_reg - MAGIC_FIRST)))
                begin
                    magic_ok_next = 1'b0;
                end
                if (hdr_idx_reg == HDR_LAST)
                begin
                    if (first_pending_reg && !magic_ok_reg)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (name_empty_reg)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        if (type_reg == CHAR_ZERO || type_reg == CHAR_NUL)
                        begin
                            rec0.record_kind   = REC_FILE;
                            rec0.entry_index   = regular_count_reg;
                            rec0.data_offset   = 32'(pos_reg + 1'b1);
                            rec0.file_size     = size_reg;
                            n                  = 2'd1;
                            regular_count_next = regular_count_reg + 1'b1;
                        end
                        skip_next      = rounded;
                        in_header_next = (rounded == '0);
                    end
                    first_pending_next = 1'b0;
                    hdr_idx_next       = '0;
                    size_next          = '0;
                    size_ended_next    = 1'b0;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                end
            end
            else
            begin
                skip_next = skip_reg - 1'b1;
                if (skip_next == '0)
                begin
                    in_header_next = 1'b1;
                end
            end
        end

        if (in_final_reg)
        begin
            if (first_pending_next)
            begin
                status = STATUS_SHORT;
            end
            else if (!magic_ok_next)
            begin
                status = STATUS_BAD_MAGIC;
            end
            else
            begin
                status = STATUS_OK;
            end
            end_rec.record_kind = REC_END;
            end_rec.end_status  = status;
            end_rec.files_seen  = (status == STATUS_OK) ? regular_count_next : '0;
            if (n == 2'd0)
            begin
                rec0 = end_rec;
            end
            else
            begin
                rec1 = end_rec;
            end
            n = n + 1'b1;

            pos_next           = '0;
            hdr_idx_next       = '0;
            in_header_next     = 1'b1;
            skip_next          = '0;
            size_next          = '0;
            size_ended_next    = 1'b0;
            type_next          = CHAR_NUL;
            name_empty_next    = 1'b0;
            magic_ok_next      = 1'b1;
            first_pending_next = 1'b1;
            stopped_next       = 1'b0;
            regular_count_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end

        if (n == 2'd1)
        begin
            rec0.last_of_run = 1'b1;
        end
        else if (n == 2'd2)
        begin
            rec1.last_of_run = 1'b1;
        end

        push.count  = fire ? n : 2'd0;
        push.first  = rec0;
        push.second = rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            hdr_idx_reg       <= '0;
            in_header_reg     <= 1'b1;
            skip_reg          <= '0;
            size_reg          <= '0;
            size_ended_reg    <= 1'b0;
            type_reg          <= CHAR_NUL;
            name_empty_reg    <= 1'b0;
            magic_ok_reg      <= 1'b1;
            first_pending_reg <= 1'b1;
            stopped_reg       <= 1'b0;
            regular_count_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg           <= pos_next;
            hdr_idx_reg       <= hdr_idx_next;
            in_header_reg     <= in_header_next;
            skip_reg          <= skip_next;
            size_reg          <= size_next;
            size_ended_reg    <= size_ended_next;
            type_reg          <= type_next;
            name_empty_reg    <= name_empty_next;
            magic_ok_reg      <= magic_ok_next;
            first_pending_reg <= first_pending_next;
            stopped_reg       <= stopped_next;
            regular_count_reg <= regular_count_next;
        end
    end

`ifndef ASSERT_OFF
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_final_reg |=> pos_reg == '0 && first_pending_reg && !stopped_reg)
        else $error("walk state not restarted after final byte");

    a_stopped_no_file: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && push.count != 2'd0 |-> push.count == 2'd1
        && push.first.record_kind == REC_END)
        else $error("file record pushed while walk is stopped");

    a_no_push_without_room: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> push.count == 2'd0 && !fire)
        else $error("records pushed without queue room");
`endif

endmodule

FILE: hw/rtl/ustar_result_fifo.sv
// ----------------------------------------------------------------------------
// USTAR result queue
// Small queue that takes up to two records per cycle and hands one record
// per cycle to the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module ustar_result_fifo import ustar_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  ustar_push_t  push,
    output logic         room,
    ustar_out_if.source  result_out
);

    ustar_result_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign room              = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign result_out.valid  = (count_reg != '0);
    assign result_out.data   = mem_reg[rd_ptr_reg];
    assign pop               = result_out.valid && result_out.ready;
    assign count_next        = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count not decremented on pop");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.record_kind == REC_FILE
        && !push.first.last_of_run && push.second.record_kind == REC_END
        && push.second.last_of_run)
        else $error("record pair out of order");
`endif

endmodule

FILE: hw/rtl/ustar_archive_entry_walker.sv
// ----------------------------------------------------------------------------
// USTAR archive entry walker
// Walks a USTAR archive byte stream and reports regular file entries.
// ----------------------------------------------------------------------------
// The archive enters on byte_in, one byte per item, with is_final set on
// the last byte. Records leave on result_out: a file record for each
// complete header of a regular file, and an end record on the final byte.
// A final byte that completes a file header gives the file record first
// and the end record next; last_of_run marks the last record of a byte.
// Each byte is taken into an input register and parsed from there; its
// records are written into the result queue, which drives result_out.
// The block takes one byte every cycle while the queue has room; this
// rate is set by the parser, which updates its walk state for each byte.
// Records wait in a four-entry queue. When the receiver stalls the queue
// fills and byte_in.ready falls once fewer than two entries are free,
// so no record is lost. After reset, and after each final byte, the walk
// starts over at offset zero with no files counted.
// ----------------------------------------------------------------------------
module ustar_archive_entry_walker import ustar_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    ustar_in_if.sink     byte_in,
    ustar_out_if.source  result_out
);

    ustar_push_t push;
    logic        room;

    ustar_hdr_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .room    (room),
        .push    (push)
    );

    ustar_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .result_out (result_out)
    );

endmodule

FILE: sim/ustar_archive_entry_walker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// USTAR archive entry walker testbench
// A short table covers a one-byte archive, a file header completed by the
// final byte and a first header with bad magic. Random short archives of
// noise follow under four patterns of sender idling and receiver stalls.
// Every record is checked against a typed-in value or an in-bench parser.
// ----------------------------------------------------------------------------
module ustar_archive_entry_walker_test;
    import ustar_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASE_BYTES   = 130;
    localparam int          DRILL_COUNT   = 3;
    localparam int          PRINT_LIMIT   = 40;
    localparam logic [39:0] MAGIC_TEXT    = "ustar";

    typedef struct {
        int unsigned   length;
        logic          blank_name;
        logic          magic_ok;
        logic [7:0]    kind;
        logic [95:0]   size_text;
        logic [7:0]    fill;
        int            typed;
        logic [31:0]   file_bytes;
        logic [1:0]    status;
        logic [22:0]   files;
    } drill_t;

    logic clk;
    logic rst_n;

    ustar_in_if  byte_in ();
    ustar_out_if result_out ();

    ustar_archive_entry_walker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .result_out (result_out)
    );

    // Parser state kept by the bench.
    logic [31:0]          walk_pos;
    logic [8:0]           hdr_pos;
    logic                 in_hdr;
    logic [31:0]          skip_left;
    logic [31:0]          size_acc;
    logic                 size_done;
    logic [7:0]           type_code;
    logic                 name_blank;
    logic                 magic_good;
    logic                 first_hdr;
    logic                 halted;
    logic [COUNT_W-1:0]   regular_count;

    ustar_result_t expected_records [$];
    logic [7:0]    archive_q [$];
    drill_t        drills [DRILL_COUNT];

    logic quiet;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   bytes_sent;
    int   archives_walked;
    int   records_checked;
    int   mismatches;
    int   cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic clear_walk();
        walk_pos      = '0;
        hdr_pos       = '0;
        in_hdr        = 1'b1;
        skip_left     = '0;
        size_acc      = '0;
        size_done     = 1'b0;
        type_code     = CHAR_NUL;
        name_blank    = 1'b0;
        magic_good    = 1'b1;
        first_hdr     = 1'b1;
        halted        = 1'b0;
        regular_count = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        ustar_result_t recs [2];
        int            n;
        int            k;
        n = 0;
        recs[0] = '0;
        recs[1] = '0;
        if (!halted)
        begin
            if (in_hdr)
            begin
                if (hdr_pos == NAME_POS)
                    name_blank = (b == CHAR_NUL);
                if (hdr_pos >= SIZE_FIRST && hdr_pos < SIZE_END && !size_done)
                begin
                    if (b == CHAR_NUL)
                        size_done = 1'b1;
                    else if (b >= CHAR_ZERO && b <= CHAR_SEVEN)
                        size_acc = {size_acc[28:0], 3'(b - CHAR_ZERO)};
                end
                if (hdr_pos == TYPE_POS)
                    type_code = b;
                if (hdr_pos >= MAGIC_FIRST && hdr_pos < MAGIC_END && first_hdr)
                begin
                    k = int'(hdr_pos - MAGIC_FIRST);
                    if (b != MAGIC_TEXT[39 - 8 * k -: 8])
                        magic_good = 1'b0;
                end
                if (hdr_pos == HDR_LAST)
                begin
                    if ((first_hdr && !magic_good) || name_blank)
                        halted = 1'b1;
                    else
                    begin
                        if (type_code == CHAR_ZERO || type_code == CHAR_NUL)
                        begin
                            recs[n].record_kind = REC_FILE;
                            recs[n].entry_index = regular_count;
                            recs[n].data_offset = walk_pos + 32'd1;
                            recs[n].file_size   = size_acc;
                            n++;
                            regular_count = regular_count + 1'b1;
                        end
                        skip_left = (size_acc + BLOCK_ROUND) & BLOCK_MASK;
                        in_hdr    = (skip_left == 0);
                    end
                    first_hdr = 1'b0;
                    hdr_pos   = '0;
                    size_acc  = '0;
                    size_done = 1'b0;
                end
                else
                    hdr_pos = hdr_pos + 1'b1;
            end
            else
            begin
                skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                    in_hdr = 1'b1;
            end
        end
        if (fin)
        begin
            recs[n].record_kind = REC_END;
            if (first_hdr)
                recs[n].end_status = STATUS_SHORT;
            else if (!magic_good)
                recs[n].end_status = STATUS_BAD_MAGIC;
            else
            begin
                recs[n].end_status = STATUS_OK;
                recs[n].files_seen = regular_count;
            end
            n++;
            clear_walk();
        end
        else
            walk_pos = walk_pos + 32'd1;
        if (n > 0)
            recs[n - 1].last_of_run = 1'b1;
        for (k = 0; k < n; k++)
        begin
            if (!quiet)
                expected_records.push_back(recs[k]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        byte_in.valid <= 1'b1;
        byte_in.data  <= {b, fin};
        @(posedge clk);
        while (!byte_in.ready)
            @(posedge clk);
        parse_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_archive();
        int i;
        for (i = 0; i < archive_q.size(); i++)
            send_byte(archive_q[i], i == archive_q.size() - 1);
        archives_walked++;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (expected_records.size() != 0);
    endtask

    task automatic add_noise(input int count);
        int i;
        for (i = 0; i < count; i++)
            archive_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic gen_archive();
        archive_q.delete();
        add_noise($urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 60));
    endtask

    function automatic drill_t make_drill(input int unsigned length, input logic blank,
                                          input logic magic_ok, input logic [7:0] kind,
                                          input logic [95:0] size_text, input logic [7:0] fill,
                                          input int typed, input logic [31:0] file_bytes,
                                          input logic [1:0] status, input logic [22:0] files);
        drill_t d;
        d.length     = length;
        d.blank_name = blank;
        d.magic_ok   = magic_ok;
        d.kind       = kind;
        d.size_text  = size_text;
        d.fill       = fill;
        d.typed      = typed;
        d.file_bytes = file_bytes;
        d.status     = status;
        d.files      = files;
        return d;
    endfunction

    task automatic build_drill(input drill_t d);
        logic [7:0] b;
        int         i;
        archive_q.delete();
        for (i = 0; i < d.length; i++)
        begin
            b = d.fill;
            if (i == NAME_POS)
                b = d.blank_name ? CHAR_NUL : 8'h61;
            else if (i >= SIZE_FIRST && i < SIZE_END)
                b = d.size_text[95 - 8 * (i - SIZE_FIRST) -: 8];
            else if (i == TYPE_POS)
                b = d.kind;
            else if (i >= MAGIC_FIRST && i < MAGIC_END)
                b = MAGIC_TEXT[39 - 8 * (i - MAGIC_FIRST) -: 8];
            if (i == MAGIC_END - 1 && !d.magic_ok)
                b = 8'h52;
            archive_q.push_back(b);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_records
        ustar_result_t want;
        ustar_result_t got;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            got = result_out.data;
            if (expected_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: record with nothing expected, got %h", $time, got);
            end
            else
            begin
                want = expected_records.pop_front();
                records_checked++;
                check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
                check_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
                check_field("data_offset", want.data_offset, got.data_offset);
                check_field("file_size", want.file_size, got.file_size);
                check_field("end_status", 32'(want.end_status), 32'(got.end_status));
                check_field("files_seen", 32'(want.files_seen), 32'(got.files_seen));
                check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            end
        end
        result_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : stimulus
        ustar_result_t rec;
        int            r;
        int            ph;
        int            base_bytes;
        rst_n             = 1'b0;
        byte_in.valid     = 1'b0;
        byte_in.data      = '0;
        result_out.ready  = 1'b0;
        quiet             = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        bytes_sent        = 0;
        archives_walked   = 0;
        records_checked   = 0;
        mismatches        = 0;
        cycle_count       = 0;
        clear_walk();

        drills[0] = make_drill(1, 1, 1, CHAR_ZERO, {12{CHAR_ZERO}}, 8'h00,
                               1, 0, STATUS_SHORT, 0);
        drills[1] = make_drill(512, 0, 1, CHAR_ZERO, {"00000000017", CHAR_NUL}, 8'h00,
                               2, 15, STATUS_OK, 1);
        drills[2] = make_drill(512, 0, 0, CHAR_ZERO, {"00000000017", CHAR_NUL}, 8'h00,
                               1, 0, STATUS_BAD_MAGIC, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DRILL_COUNT; r++)
        begin
            build_drill(drills[r]);
            if (drills[r].typed == 2)
            begin
                rec = '0;
                rec.record_kind = REC_FILE;
                rec.data_offset = 32'd512;
                rec.file_size   = drills[r].file_bytes;
                expected_records.push_back(rec);
            end
            if (drills[r].typed != 0)
            begin
                rec = '0;
                rec.record_kind = REC_END;
                rec.end_status  = drills[r].status;
                rec.files_seen  = drills[r].files;
                rec.last_of_run = 1'b1;
                expected_records.push_back(rec);
            end
            quiet = (drills[r].typed != 0);
            send_archive();
            byte_in.valid <= 1'b0;
            drain();
            quiet = 1'b0;
        end

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            base_bytes = bytes_sent;
            while (bytes_sent - base_bytes < PHASE_BYTES)
            begin
                gen_archive();
                send_archive();
            end
            byte_in.valid <= 1'b0;
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Walked %0d archives, %0d bytes, through the case table and four handshake mixes.",
                 archives_walked, bytes_sent);
        $display("Checked %0d records, %0d mismatching fields.", records_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ustar_pkg.sv
hw/rtl/ustar_if.sv
hw/rtl/ustar_hdr_parser.sv
hw/rtl/ustar_result_fifo.sv
hw/rtl/ustar_archive_entry_walker.sv
sim/ustar_archive_entry_walker_test.sv
